/* sv/plsx_pkg.sv */
// ----------------------------------------------------------------------------
// plsx_pkg - shared types and constants
// Item, configuration and state types for the percentile levels stretch.
// ----------------------------------------------------------------------------
package plsx_pkg;

	localparam int          MAX_PIXELS = 4194304;
	localparam int          CNT_W      = 23;
	localparam int          CNT_MAX    = (1 << CNT_W) - 1;
	localparam int          PIX_CAP_I  = (MAX_PIXELS > CNT_MAX) ? CNT_MAX : MAX_PIXELS;
	localparam logic [CNT_W-1:0] PIX_CAP = CNT_W'(PIX_CAP_I);
	localparam int          BINS       = 256;
	localparam int          THR_W      = 30;
	localparam int          FIFO_DEPTH = 4;

	localparam logic [1:0] REG_LOW_PCT  = 2'd0;
	localparam logic [1:0] REG_HIGH_PCT = 2'd1;
	localparam logic [1:0] REG_MIN_SPAN = 2'd2;
	localparam logic [1:0] REG_WIDEN    = 2'd3;

	localparam logic OP_HIST  = 1'b0;
	localparam logic OP_APPLY = 1'b1;

	typedef struct packed {
		logic        op;
		logic [31:0] pixel;
		logic        last;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	typedef struct packed {
		logic clearing;
	} bk_stat_t;

	typedef struct packed {
		logic [6:0] low_pct;
		logic [6:0] high_pct;
		logic [7:0] min_span;
		logic [7:0] widen_step;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_HUPD,
		ST_SMUL,
		ST_SWEEP,
		ST_SFIN,
		ST_DIV,
		ST_AOUT
	} bk_state_t;

	typedef enum logic [1:0] {
		LM_PASS,
		LM_ZERO,
		LM_DIV
	} lane_mode_t;

	function automatic logic [6:0] pct_clamp(input logic [6:0] p);
		return (p > 7'd100) ? 7'd100 : p;
	endfunction

endpackage

/* sv/plsx_ram.sv */
// ----------------------------------------------------------------------------
// plsx_ram - generic RAM
// One write port, one read port, registered read (old data on collision).
// ----------------------------------------------------------------------------
module plsx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;
endmodule

/* sv/plsx_front.sv */
// ----------------------------------------------------------------------------
// plsx_front - input queue
// Takes pixel beats and holds them until the back end picks them up.
// ----------------------------------------------------------------------------
module plsx_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  plsx_pkg::item_t   item,
	input  plsx_pkg::bk_stat_t stat,
	output plsx_pkg::head_t   head,
	input  logic              take
);
	import plsx_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);

	item_t         buf_q [FIFO_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;
	logic          do_push, do_pop;

	// no beat taken while the histograms are being cleared after reset
	assign full    = (cnt_q == (PW+1)'(FIFO_DEPTH)) || stat.clearing;
	assign do_push = push && !full;
	assign do_pop  = take && (cnt_q != '0);

	assign head.valid = (cnt_q != '0);
	assign head.item  = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop)  rd_q <= rd_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

/* sv/plsx_div.sv */
// ----------------------------------------------------------------------------
// plsx_div - three-lane restoring divider
// 16-bit by 8-bit unsigned, one quotient bit per cycle per lane.
// ----------------------------------------------------------------------------
module plsx_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] num [3],
	input  logic [7:0]  den [3],
	output logic        done,
	output logic [15:0] quo [3]
);
	logic [15:0] nq_q  [3];
	logic [7:0]  den_q [3];
	logic [7:0]  rem_q [3];
	logic [3:0]  cnt_q;
	logic        busy_q, done_q;

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			if (start) begin
				nq_q[l]  <= num[l];
				den_q[l] <= den[l];
				rem_q[l] <= '0;
			end else if (busy_q) begin
				if ({rem_q[l], nq_q[l][15]} >= {1'b0, den_q[l]}) begin
					rem_q[l] <= 8'({rem_q[l], nq_q[l][15]} - {1'b0, den_q[l]});
					nq_q[l]  <= {nq_q[l][14:0], 1'b1};
				end else begin
					rem_q[l] <= {rem_q[l][6:0], nq_q[l][15]};
					nq_q[l]  <= {nq_q[l][14:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 4'd15);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 4'd15) busy_q <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign quo  = nq_q;
endmodule

/* sv/plsx_back.sv */
// ----------------------------------------------------------------------------
// plsx_back - execution back end
// Histogram update, per-frame level search and per-pixel stretch.
// ----------------------------------------------------------------------------
module plsx_back (
	input  logic                clk,
	input  logic                arst_n,
	input  plsx_pkg::cfg_t      cfg,
	input  plsx_pkg::head_t     head,
	output logic                take,
	output plsx_pkg::bk_stat_t  stat,
	output logic                empty,
	input  logic                pop,
	output logic [31:0]         pixel_out,
	output logic                last_out
);
	import plsx_pkg::*;

	bk_state_t   state_q, state_d;
	item_t       item_q;
	logic [8:0]  idx_q;
	logic [CNT_W-1:0] seen_q;
	logic [THR_W-1:0] lo_thr_q, hi_thr_q;
	logic        rd_vld_s1;
	logic [7:0]  rd_idx_s1;

	logic [CNT_W-1:0] run_q [3];
	logic [7:0]  slo_q [3];
	logic [7:0]  shi_q [3];
	logic        found_q [3];
	logic [7:0]  lvl_lo_q [3];
	logic [7:0]  lvl_hi_q [3];
	lane_mode_t  mode_q [3];
	logic [7:0]  val_q [3];

	logic        out_vld_q;
	logic [31:0] out_px_q;
	logic        out_last_q;

	logic        we;
	logic [7:0]  waddr [3];
	logic [7:0]  raddr [3];
	logic [CNT_W-1:0] wdata [3];
	logic [CNT_W-1:0] rdata [3];

	logic        div_start, div_done;
	logic [15:0] div_num [3];
	logic [7:0]  div_den [3];
	logic [15:0] div_quo [3];

	logic        out_free;
	logic [7:0]  res [3];

	assign out_free = !out_vld_q || pop;

	for (genvar c = 0; c < 3; c++) begin : g_hist
		plsx_ram #(.WIDTH(CNT_W), .DEPTH(BINS)) u_ram (
			.clk  (clk),
			.we   (we),
			.waddr(waddr[c]),
			.wdata(wdata[c]),
			.raddr(raddr[c]),
			.rdata(rdata[c])
		);
	end

	plsx_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	// stretch set-up for the head pixel
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			logic [7:0] v, d;
			v = head.item.pixel[8*c +: 8];
			d = v - lvl_lo_q[c];
			div_num[c] = {d, 8'h00} - {8'h00, d};
			div_den[c] = lvl_hi_q[c] - lvl_lo_q[c];
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			unique case (mode_q[c])
				LM_PASS: res[c] = val_q[c];
				LM_ZERO: res[c] = 8'h00;
				LM_DIV:  res[c] = (div_quo[c] > 16'd255) ? 8'hFF : div_quo[c][7:0];
				default: res[c] = val_q[c];
			endcase
		end
	end

	// next state and strobes
	always_comb begin
		state_d   = state_q;
		take      = 1'b0;
		div_start = 1'b0;
		we        = 1'b0;
		for (int c = 0; c < 3; c++) begin
			raddr[c] = head.item.pixel[8*c +: 8];
			waddr[c] = idx_q[7:0];
			wdata[c] = '0;
		end
		unique case (state_q)
			ST_CLR: begin
				we = 1'b1;
				if (idx_q[7:0] == 8'hFF) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (head.valid) begin
					take = 1'b1;
					if (head.item.op == OP_HIST) begin
						state_d = ST_HUPD;
					end else begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
				end
			end
			ST_HUPD: begin
				we = (seen_q < PIX_CAP);
				for (int c = 0; c < 3; c++) begin
					waddr[c] = item_q.pixel[8*c +: 8];
					wdata[c] = rdata[c] + 1'b1;
				end
				state_d = item_q.last ? ST_SMUL : ST_IDLE;
			end
			ST_SMUL: state_d = ST_SWEEP;
			ST_SWEEP: begin
				we = !idx_q[8];
				for (int c = 0; c < 3; c++) raddr[c] = idx_q[7:0];
				if (idx_q[8] && !rd_vld_s1) state_d = ST_SFIN;
			end
			ST_SFIN: state_d = ST_IDLE;
			ST_DIV:  if (div_done) state_d = ST_AOUT;
			ST_AOUT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLR;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (take) item_q <= head.item;
	end

	// control and level state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			seen_q     <= '0;
			rd_vld_s1  <= 1'b0;
			out_vld_q  <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				lvl_lo_q[c] <= 8'h00;
				lvl_hi_q[c] <= 8'hFF;
				found_q[c]  <= 1'b0;
			end
		end else begin
			rd_vld_s1 <= (state_q == ST_SWEEP) && !idx_q[8];
			if (state_q == ST_CLR || state_q == ST_SWEEP) idx_q <= idx_q + 1'b1;
			if (state_q == ST_SMUL) begin
				idx_q <= '0;
				for (int c = 0; c < 3; c++) found_q[c] <= 1'b0;
			end
			if (state_q == ST_HUPD && seen_q < PIX_CAP) seen_q <= seen_q + 1'b1;
			if (state_q == ST_SWEEP && rd_vld_s1) begin
				for (int c = 0; c < 3; c++) begin
					logic [CNT_W-1:0] cum;
					cum = run_q[c] + rdata[c];
					if (!found_q[c] && (lo_thr_q < THR_W'(cum) * THR_W'(100))) begin
						found_q[c] <= 1'b1;
					end
				end
			end
			if (state_q == ST_SFIN) begin
				seen_q <= '0;
				for (int c = 0; c < 3; c++) begin
					logic signed [9:0] span;
					logic [8:0] hw;
					span = $signed({2'b00, shi_q[c]}) - $signed({2'b00, slo_q[c]});
					hw   = {1'b0, shi_q[c]} + {1'b0, cfg.widen_step};
					if (span < $signed({2'b00, cfg.min_span})) begin
						lvl_lo_q[c] <= (slo_q[c] > cfg.widen_step) ? slo_q[c] - cfg.widen_step
						                                            : 8'h00;
						lvl_hi_q[c] <= hw[8] ? 8'hFF : hw[7:0];
					end else begin
						lvl_lo_q[c] <= slo_q[c];
						lvl_hi_q[c] <= shi_q[c];
					end
				end
			end
			if (state_q == ST_AOUT && out_free) out_vld_q <= 1'b1;
			else if (pop)                       out_vld_q <= 1'b0;
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[7:0];
		if (state_q == ST_SMUL) begin
			lo_thr_q <= THR_W'(pct_clamp(cfg.low_pct)) * THR_W'(seen_q);
			hi_thr_q <= THR_W'(pct_clamp(cfg.high_pct)) * THR_W'(seen_q);
			for (int c = 0; c < 3; c++) begin
				run_q[c] <= '0;
				slo_q[c] <= 8'h00;
				shi_q[c] <= 8'h00;
			end
		end
		if (state_q == ST_SWEEP && rd_vld_s1) begin
			for (int c = 0; c < 3; c++) begin
				logic [CNT_W-1:0] cum;
				cum = run_q[c] + rdata[c];
				run_q[c] <= cum;
				// running sum passes the dark threshold: first such bin
				if (!found_q[c] && (lo_thr_q < THR_W'(cum) * THR_W'(100))) begin
					slo_q[c] <= (rd_idx_s1 != 8'h00) ? rd_idx_s1 - 1'b1 : 8'h00;
				end
				// still below the bright threshold: last such bin wins
				if ((THR_W'(cum) + THR_W'(1)) * THR_W'(100) <= hi_thr_q) begin
					shi_q[c] <= (rd_idx_s1 != 8'hFF) ? rd_idx_s1 + 1'b1 : 8'hFF;
				end
			end
		end
		if (state_q == ST_IDLE && take && head.item.op == OP_APPLY) begin
			for (int c = 0; c < 3; c++) begin
				val_q[c] <= head.item.pixel[8*c +: 8];
				if (lvl_hi_q[c] <= lvl_lo_q[c])                    mode_q[c] <= LM_PASS;
				else if (head.item.pixel[8*c +: 8] <= lvl_lo_q[c]) mode_q[c] <= LM_ZERO;
				else                                               mode_q[c] <= LM_DIV;
			end
		end
		if (state_q == ST_AOUT && out_free) begin
			out_px_q   <= {item_q.pixel[31:24], res[2], res[1], res[0]};
			out_last_q <= item_q.last;
		end
	end

	assign stat.clearing = (state_q == ST_CLR);
	assign empty         = !out_vld_q;
	assign pixel_out     = out_px_q;
	assign last_out      = out_last_q;

	a_hupd_after_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HUPD) |-> ($past(state_q) == ST_IDLE))
		else $error("histogram update without a fetched item");

	a_seen_capped: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= PIX_CAP)
		else $error("pixel counter beyond cap");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (state_q == ST_DIV))
		else $error("divider started outside apply");

	a_no_take_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !take)
		else $error("item taken during clear");
endmodule

/* sv/percentile_levels_stretch.sv */
// ----------------------------------------------------------------------------
// percentile_levels_stretch - percentile auto levels
// Two-pass contrast stretch of 32-bit pixels over byte channels 0 to 2.
// ----------------------------------------------------------------------------
// Usage: after reset the three 256-bin histograms are swept to zero, with
// full held high. Histogram-pass beats (op=0) do a read-modify-write on the
// bin memories and give no result; the frame_end beat of that pass then
// runs the level search, one bin of all three histograms per cycle, zeroing
// bins as it goes. Apply-pass beats (op=1) run the 16-step quotient loop of
// the three-lane divider and give one result each. An input queue of four
// beats and a result register keep the two sides decoupled.
// Configuration writes are accepted at once (cfg_ready is always high).
// ----------------------------------------------------------------------------
module percentile_levels_stretch (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        op,
	input  logic [31:0] pixel_in,
	input  logic        frame_end,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] pixel_out,
	output logic        last_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import plsx_pkg::*;

	cfg_t     cfg_q;
	item_t    in_item;
	head_t    head;
	bk_stat_t stat;
	logic     take;

	assign cfg_ready = 1'b1;

	// register file, reset to the usual 5 / 95 percent with a span of 10
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_pct    <= 7'd5;
			cfg_q.high_pct   <= 7'd95;
			cfg_q.min_span   <= 8'd10;
			cfg_q.widen_step <= 8'd5;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LOW_PCT:  cfg_q.low_pct    <= cfg_data[6:0];
				REG_HIGH_PCT: cfg_q.high_pct   <= cfg_data[6:0];
				REG_MIN_SPAN: cfg_q.min_span   <= cfg_data;
				REG_WIDEN:    cfg_q.widen_step <= cfg_data;
				default:      cfg_q            <= cfg_q;
			endcase
		end
	end

	assign in_item.op    = op;
	assign in_item.pixel = pixel_in;
	assign in_item.last  = frame_end;

	plsx_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (in_item),
		.stat  (stat),
		.head  (head),
		.take  (take)
	);

	plsx_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head),
		.take     (take),
		.stat     (stat),
		.empty    (empty),
		.pop      (pop),
		.pixel_out(pixel_out),
		.last_out (last_out)
	);
endmodule
